// File: rtl/sfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpa_pkg
// Types and constants shared by the saturating fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package sfpa_pkg;

	localparam int DIV_BITS = 32;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		MODE_Q15_ADD = 3'd0,
		MODE_Q15_SUB = 3'd1,
		MODE_Q15_MUL = 3'd2,
		MODE_Q15_DIV = 3'd3,
		MODE_Q31_ADD = 3'd4,
		MODE_Q31_SUB = 3'd5,
		MODE_Q31_MUL = 3'd6,
		MODE_Q31_DIV = 3'd7
	} mode_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num_lo;
		logic [31:0] dvs;
		logic [31:0] quo;
	} div_t;

	typedef struct packed {
		logic        valid;
		logic        is_div;
		logic        neg;
		logic        rnd;
		logic        ovf;
		logic [31:0] res;
	} side_t;

endpackage
`default_nettype wire

// File: rtl/sfpa_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpa_div_step
// One restoring division step that produces a single quotient bit.
// ----------------------------------------------------------------------------
module sfpa_div_step (
	input  wire sfpa_pkg::div_t d_in,
	output sfpa_pkg::div_t d_out
);

	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;

	always_comb begin
		trial = {d_in.rem, d_in.num_lo[31]};
		ge = trial >= {1'b0, d_in.dvs};
		diff = trial - {1'b0, d_in.dvs};
		d_out.rem = ge ? diff[31:0] : trial[31:0];
		d_out.num_lo = {d_in.num_lo[30:0], 1'b0};
		d_out.dvs = d_in.dvs;
		d_out.quo = {d_in.quo[30:0], ge};
	end

endmodule
`default_nettype wire

// File: rtl/sfpa_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpa_divider
// Pipelined divider, one quotient bit per stage, with sideband carried along.
// ----------------------------------------------------------------------------
module sfpa_divider (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            en,
	input  wire sfpa_pkg::div_t  div_in,
	input  wire sfpa_pkg::side_t side_in,
	output sfpa_pkg::div_t  div_out,
	output sfpa_pkg::side_t side_out
);

	localparam int N = sfpa_pkg::DIV_BITS;

	sfpa_pkg::div_t  div_s  [0:N-1];
	sfpa_pkg::side_t side_s [0:N-1];
	sfpa_pkg::div_t  nxt    [0:N-1];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_stage
			if (i == 0) begin : g_first
				sfpa_div_step u_step (.d_in(div_in), .d_out(nxt[i]));
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						side_s[i] <= '0;
					end else if (en) begin
						side_s[i] <= side_in;
					end
				end
			end else begin : g_rest
				sfpa_div_step u_step (.d_in(div_s[i-1]), .d_out(nxt[i]));
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						side_s[i] <= '0;
					end else if (en) begin
						side_s[i] <= side_s[i-1];
					end
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					div_s[i] <= nxt[i];
				end
			end
		end
	endgenerate

	assign div_out = div_s[N-1];
	assign side_out = side_s[N-1];

endmodule
`default_nettype wire

// File: rtl/saturating_fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// A request is registered on acceptance, then passes two more front stages,
// the 32-stage bit-per-stage divider and the output stage. Throughput is
// one request per cycle while the output is not stalled; every operation
// walks the same pipeline. A stalled output freezes the whole pipeline, so
// nothing is lost or repeated. Reset clears all valid bits and the sideband
// registers asynchronously; the other data registers are not reset.
// ----------------------------------------------------------------------------
// saturating_fixed_point_alu
// Saturating Q17.15 and Q1.31 add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
module saturating_fixed_point_alu (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [2:0]        mode,
	input  wire  signed [31:0] operand_a,
	input  wire  signed [31:0] operand_b,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] result_value
);

	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	logic               v_s1;
	sfpa_pkg::mode_t    mode_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= sfpa_pkg::mode_t'(mode);
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
	end

	logic               v_s2;
	sfpa_pkg::mode_t    mode_s2;
	logic signed [63:0] prod_s2;
	logic signed [32:0] sum_s2;
	logic [31:0]        abs_a_s2;
	logic [31:0]        abs_b_s2;
	logic               sa_s2;
	logic               sb_s2;
	logic               bz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			prod_s2 <= 64'(a_s1) * 64'(b_s1);
			sum_s2 <= mode_s1[0] ? (33'(a_s1) - 33'(b_s1)) : (33'(a_s1) + 33'(b_s1));
			abs_a_s2 <= a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
			abs_b_s2 <= b_s1[31] ? 32'(-b_s1) : 32'(b_s1);
			sa_s2 <= a_s1[31];
			sb_s2 <= b_s1[31];
			bz_s2 <= b_s1 == 32'sd0;
		end
	end

	logic signed [63:0] rnd_prod;
	logic signed [63:0] shifted;
	logic [31:0]        mul_res;
	logic [31:0]        sum_res;
	logic [63:0]        num;
	sfpa_pkg::div_t     div_c;
	sfpa_pkg::side_t    side_c;

	always_comb begin
		if (mode_s2[2]) begin
			rnd_prod = prod_s2 + 64'sh4000_0000;
			shifted = rnd_prod >>> 31;
			num = {32'd0, abs_a_s2} << 31;
		end else begin
			rnd_prod = prod_s2 + 64'sh4000;
			shifted = rnd_prod >>> 15;
			num = {32'd0, abs_a_s2} << 15;
		end
		if (shifted > 64'sh7FFF_FFFF) begin
			mul_res = sfpa_pkg::SAT_MAX;
		end else if (shifted < -64'sh8000_0000) begin
			mul_res = sfpa_pkg::SAT_MIN;
		end else begin
			mul_res = shifted[31:0];
		end
		if (sum_s2[32] != sum_s2[31]) begin
			sum_res = sum_s2[32] ? sfpa_pkg::SAT_MIN : sfpa_pkg::SAT_MAX;
		end else begin
			sum_res = sum_s2[31:0];
		end
		div_c.rem = num[63:32];
		div_c.num_lo = num[31:0];
		div_c.dvs = abs_b_s2;
		div_c.quo = '0;
		side_c.valid = v_s2;
		side_c.neg = sa_s2 ^ sb_s2;
		side_c.rnd = mode_s2[2];
		side_c.ovf = num[63:32] >= abs_b_s2;
		side_c.is_div = 1'b0;
		unique case (mode_s2)
			sfpa_pkg::MODE_Q15_ADD, sfpa_pkg::MODE_Q15_SUB,
			sfpa_pkg::MODE_Q31_ADD, sfpa_pkg::MODE_Q31_SUB: begin
				side_c.res = sum_res;
			end
			sfpa_pkg::MODE_Q15_MUL, sfpa_pkg::MODE_Q31_MUL: begin
				side_c.res = mul_res;
			end
			sfpa_pkg::MODE_Q15_DIV, sfpa_pkg::MODE_Q31_DIV: begin
				side_c.res = sa_s2 ? sfpa_pkg::SAT_MIN : sfpa_pkg::SAT_MAX;
				side_c.is_div = !bz_s2;
			end
			default: begin
				side_c.res = sum_res;
			end
		endcase
	end

	sfpa_pkg::div_t  div_s3;
	sfpa_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= side_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s3 <= div_c;
		end
	end

	sfpa_pkg::div_t  div_fin;
	sfpa_pkg::side_t side_fin;

	sfpa_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.div_in  (div_s3),
		.side_in (side_s3),
		.div_out (div_fin),
		.side_out(side_fin)
	);

	logic        half;
	logic [32:0] qmag;
	logic [32:0] qneg;
	logic [31:0] div_res;
	logic [31:0] fin_res;

	always_comb begin
		half = {div_fin.rem, 1'b0} >= {1'b0, div_fin.dvs};
		qmag = {1'b0, div_fin.quo} + {32'd0, side_fin.rnd && half};
		qneg = 33'd0 - qmag;
		if (side_fin.neg) begin
			if (side_fin.ovf || qmag > {1'b0, sfpa_pkg::SAT_MIN}) begin
				div_res = sfpa_pkg::SAT_MIN;
			end else begin
				div_res = qneg[31:0];
			end
		end else begin
			if (side_fin.ovf || qmag > {1'b0, sfpa_pkg::SAT_MAX}) begin
				div_res = sfpa_pkg::SAT_MAX;
			end else begin
				div_res = qmag[31:0];
			end
		end
		fin_res = side_fin.is_div ? div_res : side_fin.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= side_fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_value <= fin_res;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("result changed while stalled");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && side_fin.valid && side_fin.is_div && side_fin.ovf |=>
		result_value == sfpa_pkg::SAT_MAX || result_value == sfpa_pkg::SAT_MIN)
		else $error("divide overflow not saturated");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(side_s3))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case requests through the saturating fixed-point
// unit and compares every result with a predicted value, in order.
// ----------------------------------------------------------------------------

class alu_scoreboard;
	logic signed [31:0] pending[$];
	int errors = 0;

	function automatic logic signed [31:0] clamp(logic signed [127:0] v);
		if (v > 128'sd2147483647) return sfpa_pkg::SAT_MAX;
		if (v < -128'sd2147483648) return sfpa_pkg::SAT_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] compute(sfpa_pkg::mode_t m,
			logic signed [31:0] a, logic signed [31:0] b);
		logic signed [127:0] wa, wb, num, q, r, ra, ba;
		wa = a;
		wb = b;
		case (m)
			sfpa_pkg::MODE_Q15_ADD, sfpa_pkg::MODE_Q31_ADD: return clamp(wa + wb);
			sfpa_pkg::MODE_Q15_SUB, sfpa_pkg::MODE_Q31_SUB: return clamp(wa - wb);
			sfpa_pkg::MODE_Q15_MUL: return clamp((wa * wb + 128'sd16384) >>> 15);
			sfpa_pkg::MODE_Q31_MUL: return clamp((wa * wb + (128'sd1 <<< 30)) >>> 31);
			default: begin
				if (b == 0) return (a >= 0) ? sfpa_pkg::SAT_MAX : sfpa_pkg::SAT_MIN;
				num = (m == sfpa_pkg::MODE_Q15_DIV) ? (wa <<< 15) : (wa <<< 31);
				q = num / wb;
				r = num % wb;
				if (m == sfpa_pkg::MODE_Q31_DIV && r != 0) begin
					ra = (r < 0) ? -r : r;
					ba = (wb < 0) ? -wb : wb;
					if (ra * 2 >= ba) q = ((a < 0) != (b < 0)) ? q - 1 : q + 1;
				end
				return clamp(q);
			end
		endcase
	endfunction

	function void note_request(sfpa_pkg::mode_t m, logic signed [31:0] a,
			logic signed [31:0] b);
		pending.push_back(compute(m, a, b));
	endfunction

	function void check_result(logic signed [31:0] got);
		logic signed [31:0] want;
		if (pending.size() == 0) begin
			$error("result_value: expected none, actual %0d", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			$error("result_value: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] mode = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] result_value;

	alu_scoreboard board = new();
	int idle_cycles = 0;
	bit hold_off = 0;
	bit stim_done = 0;

	saturating_fixed_point_alu dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			board.note_request(sfpa_pkg::mode_t'(mode), operand_a, operand_b);
		if (out_valid && out_ready)
			board.check_result(result_value);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int pattern;
		@(posedge arst_n);
		forever begin
			pattern = $urandom_range(0, 3);
			repeat ($urandom_range(5, 40)) begin
				@(posedge clk);
				if (hold_off) out_ready <= 0;
				else case (pattern)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 1) != 0);
					2: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return sfpa_pkg::SAT_MAX;
			1: return sfpa_pkg::SAT_MIN;
			2: return 0;
			3: return $signed($urandom_range(0, 200)) - 100;
			4: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
			5: return -$signed($urandom_range(0, 1 << 20));
			default: return $urandom;
		endcase
	endfunction

	task automatic send(sfpa_pkg::mode_t m, logic signed [31:0] a, logic signed [31:0] b);
		in_valid <= 1;
		mode <= m;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] corners[5];
		int burst;
		corners = '{sfpa_pkg::SAT_MAX, sfpa_pkg::SAT_MIN, 0, 1, -1};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int m = 0; m < 8; m++) begin
			send(sfpa_pkg::mode_t'(m), corners[m % 5], corners[(m + 1) % 5]);
			send(sfpa_pkg::mode_t'(m), corners[(m + 2) % 5], 0);
		end
		send(sfpa_pkg::MODE_Q31_DIV, 3, 2);
		send(sfpa_pkg::MODE_Q31_DIV, -3, 2);
		send(sfpa_pkg::MODE_Q15_DIV, -7, 2);
		send(sfpa_pkg::MODE_Q31_MUL, sfpa_pkg::SAT_MIN, sfpa_pkg::SAT_MIN);
		send(sfpa_pkg::MODE_Q15_MUL, -1, 1);
		pause();
		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			repeat (100) send(sfpa_pkg::mode_t'($urandom_range(0, 7)), pick_operand(),
				pick_operand());
		join
		in_valid <= 0;
		for (int n = 0; n < 1550; n += burst) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst; k++)
				send(sfpa_pkg::mode_t'($urandom_range(0, 7)), pick_operand(),
					pick_operand());
			if ($urandom_range(0, 2) != 0) pause();
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// File: sim.f
rtl/sfpa_pkg.sv
rtl/sfpa_div_step.sv
rtl/sfpa_divider.sv
rtl/saturating_fixed_point_alu.sv
verif/testbench.sv
